// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is asserted
`define BTOK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("btok assertion failed");

// clocked assertion that also holds during reset
`define BTOK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("btok assertion failed");

`endif

// ===== rtl/btok_pkg.sv =====
// constants, codes and the token type of the bencode tokenizer
package btok_pkg;

    localparam int MAX_DEPTH   = 16;
    localparam int DEPTH_W     = 5;
    localparam int LENGTH_BITS = 32;
    localparam int LEN_WIDE_W  = LENGTH_BITS + 4;
    localparam int INT_W       = 64;
    localparam int INT_WIDE_W  = INT_W + 4;

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // parser modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_LEN     = 3'd1;
    localparam logic [2:0] M_PAYLOAD = 3'd2;
    localparam logic [2:0] M_INT     = 3'd3;
    localparam logic [2:0] M_LIST    = 3'd4;
    localparam logic [2:0] M_DISCARD = 3'd5;

    // token kinds
    localparam logic [2:0] TK_LIST_START = 3'd0;
    localparam logic [2:0] TK_LIST_END   = 3'd1;
    localparam logic [2:0] TK_INTEGER    = 3'd2;
    localparam logic [2:0] TK_STR_HEADER = 3'd3;
    localparam logic [2:0] TK_STR_BYTE   = 3'd4;
    localparam logic [2:0] TK_ERROR      = 3'd5;

    // error codes
    localparam logic [2:0] E_BAD_CHAR     = 3'd0;
    localparam logic [2:0] E_BAD_LENGTH   = 3'd1;
    localparam logic [2:0] E_BAD_INTEGER  = 3'd2;
    localparam logic [2:0] E_INT_OVERFLOW = 3'd3;
    localparam logic [2:0] E_LEN_OVERFLOW = 3'd4;
    localparam logic [2:0] E_TOO_DEEP     = 3'd5;
    localparam logic [2:0] E_TRUNCATED    = 3'd6;
    localparam logic [2:0] E_TRAILING     = 3'd7;

    typedef struct packed {
        logic [2:0]              token_kind;
        logic signed [INT_W-1:0] int_value;
        logic [31:0]             str_length;
        logic [7:0]              data_byte;
        logic                    last_of_string;
        logic [DEPTH_W-1:0]      nest_depth;
        logic [2:0]              error_code;
        logic                    value_complete;
    } t_token;

endpackage

// ===== rtl/btok_if.sv =====
// byte input and token output channel interfaces
interface btok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface btok_out_if;
    logic                                valid;
    logic                                ready;
    logic [2:0]                          token_kind;
    logic signed [btok_pkg::INT_W-1:0]   int_value;
    logic [31:0]                         str_length;
    logic [7:0]                          data_byte;
    logic                                last_of_string;
    logic [btok_pkg::DEPTH_W-1:0]        nest_depth;
    logic [2:0]                          error_code;
    logic                                value_complete;

    modport source (output valid, output token_kind, output int_value, output str_length,
                    output data_byte, output last_of_string, output nest_depth,
                    output error_code, output value_complete, input ready);
    modport sink   (input valid, input token_kind, input int_value, input str_length,
                    input data_byte, input last_of_string, input nest_depth,
                    input error_code, input value_complete, output ready);
endinterface

// ===== rtl/bencode_tokenizer_core.sv =====
// Streaming bencode tokenizer: takes one byte per transfer and emits zero or one token for it.
// A byte is taken in every cycle unless a token sits in the output register and is not being
// taken; a byte's token is registered and shows in the next cycle. The per-byte work is one
// pass through the parser state registers: the length and integer accumulators multiply by
// ten with shift-and-add and check overflow against the widened sum. Strings, integers and
// lists up to min(depth limit, 16) levels are tokenized; after an error, bytes are dropped
// until the one marked end of input, which rearms the parser. The depth limit register may
// be written only while no byte is in flight.
module bencode_tokenizer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [btok_pkg::DEPTH_W-1:0]   i_cfg_wdata,
    btok_in_if.sink                        i_in,
    btok_out_if.source                     o_out
);

    logic [btok_pkg::DEPTH_W-1:0]     r_depth_limit;
    logic [2:0]                       r_mode,      n_mode;
    logic [btok_pkg::DEPTH_W-1:0]     r_depth,     n_depth;
    logic [btok_pkg::LENGTH_BITS-1:0] r_len,       n_len;
    logic [btok_pkg::LENGTH_BITS-1:0] r_rem,       n_rem;
    logic [btok_pkg::INT_W-1:0]       r_int,       n_int;
    logic                             r_neg,       n_neg;
    logic                             r_digit_seen, n_digit_seen;
    logic                             r_top_done,  n_top_done;
    logic                             r_out_valid;
    btok_pkg::t_token                 r_tok,       n_tok;
    logic                             n_emit;

    logic                             accept;
    logic [7:0]                       b;
    logic                             eoi;
    logic                             is_digit;
    logic [3:0]                       d;
    logic [btok_pkg::LEN_WIDE_W-1:0]  len_wide;
    logic [btok_pkg::INT_WIDE_W-1:0]  int_wide;
    logic [btok_pkg::INT_WIDE_W-1:0]  int_limit;
    logic [btok_pkg::LENGTH_BITS-1:0] rem_dec;
    logic [btok_pkg::DEPTH_W-1:0]     eff_limit;
    logic                             do_start;
    logic                             do_finish;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;

    assign b        = i_in.in_byte;
    assign eoi      = i_in.end_of_input;
    assign is_digit = (b >= btok_pkg::CH_ZERO) && (b <= btok_pkg::CH_NINE);
    assign d        = b[3:0];

    assign len_wide = (btok_pkg::LEN_WIDE_W'(r_len) << 3) + (btok_pkg::LEN_WIDE_W'(r_len) << 1)
                    + btok_pkg::LEN_WIDE_W'(d);
    assign int_wide = (btok_pkg::INT_WIDE_W'(r_int) << 3) + (btok_pkg::INT_WIDE_W'(r_int) << 1)
                    + btok_pkg::INT_WIDE_W'(d);
    // 2^63 for negative values, 2^63-1 otherwise
    assign int_limit = (btok_pkg::INT_WIDE_W'(1) << (btok_pkg::INT_W - 1))
                     - (r_neg ? btok_pkg::INT_WIDE_W'(0) : btok_pkg::INT_WIDE_W'(1));
    assign rem_dec   = r_rem - btok_pkg::LENGTH_BITS'(1);
    assign eff_limit = (r_depth_limit < btok_pkg::DEPTH_W'(btok_pkg::MAX_DEPTH))
                     ? r_depth_limit : btok_pkg::DEPTH_W'(btok_pkg::MAX_DEPTH);

    always_comb begin
        n_mode       = r_mode;
        n_depth      = r_depth;
        n_len        = r_len;
        n_rem        = r_rem;
        n_int        = r_int;
        n_neg        = r_neg;
        n_digit_seen = r_digit_seen;
        n_top_done   = r_top_done;
        n_tok        = '0;
        n_emit       = 1'b0;
        do_start     = 1'b0;
        do_finish    = 1'b0;

        if (r_mode == btok_pkg::M_DISCARD) begin
            if (eoi) begin
                n_mode = btok_pkg::M_IDLE;
            end
        end else begin
            if (r_top_done) begin
                n_mode           = btok_pkg::M_DISCARD;
                n_emit           = 1'b1;
                n_tok.token_kind = btok_pkg::TK_ERROR;
                n_tok.error_code = btok_pkg::E_TRAILING;
            end else begin
                unique case (r_mode)
                    btok_pkg::M_LEN: begin
                        if (is_digit) begin
                            if (len_wide[btok_pkg::LEN_WIDE_W-1:btok_pkg::LENGTH_BITS] != '0) begin
                                n_mode           = btok_pkg::M_DISCARD;
                                n_emit           = 1'b1;
                                n_tok.token_kind = btok_pkg::TK_ERROR;
                                n_tok.error_code = btok_pkg::E_LEN_OVERFLOW;
                            end else begin
                                n_len = len_wide[btok_pkg::LENGTH_BITS-1:0];
                            end
                        end else if (b != btok_pkg::CH_COLON) begin
                            n_mode           = btok_pkg::M_DISCARD;
                            n_emit           = 1'b1;
                            n_tok.token_kind = btok_pkg::TK_ERROR;
                            n_tok.error_code = btok_pkg::E_BAD_LENGTH;
                        end else begin
                            n_emit           = 1'b1;
                            n_tok.token_kind = btok_pkg::TK_STR_HEADER;
                            if (r_len == '0) begin
                                do_finish = 1'b1;
                            end else begin
                                n_rem            = r_len;
                                n_mode           = btok_pkg::M_PAYLOAD;
                                n_tok.str_length = 32'(r_len);
                            end
                        end
                    end
                    btok_pkg::M_PAYLOAD: begin
                        n_rem            = rem_dec;
                        n_emit           = 1'b1;
                        n_tok.token_kind = btok_pkg::TK_STR_BYTE;
                        n_tok.data_byte  = b;
                        if (rem_dec == '0) begin
                            n_tok.last_of_string = 1'b1;
                            do_finish            = 1'b1;
                        end
                    end
                    btok_pkg::M_INT: begin
                        if (is_digit) begin
                            if ((r_digit_seen && r_int == '0)
                                || (!r_digit_seen && d == 4'd0 && r_neg)) begin
                                // leading zero or minus zero
                                n_mode           = btok_pkg::M_DISCARD;
                                n_emit           = 1'b1;
                                n_tok.token_kind = btok_pkg::TK_ERROR;
                                n_tok.error_code = btok_pkg::E_BAD_INTEGER;
                            end else if (int_wide > int_limit) begin
                                n_mode           = btok_pkg::M_DISCARD;
                                n_emit           = 1'b1;
                                n_tok.token_kind = btok_pkg::TK_ERROR;
                                n_tok.error_code = btok_pkg::E_INT_OVERFLOW;
                            end else begin
                                n_int        = int_wide[btok_pkg::INT_W-1:0];
                                n_digit_seen = 1'b1;
                            end
                        end else if (b == btok_pkg::CH_MINUS && !r_digit_seen && !r_neg) begin
                            n_neg = 1'b1;
                        end else if (b == btok_pkg::CH_E && r_digit_seen) begin
                            n_emit           = 1'b1;
                            n_tok.token_kind = btok_pkg::TK_INTEGER;
                            n_tok.int_value  = r_neg ? -$signed(r_int) : $signed(r_int);
                            do_finish        = 1'b1;
                        end else begin
                            n_mode           = btok_pkg::M_DISCARD;
                            n_emit           = 1'b1;
                            n_tok.token_kind = btok_pkg::TK_ERROR;
                            n_tok.error_code = btok_pkg::E_BAD_INTEGER;
                        end
                    end
                    btok_pkg::M_LIST: begin
                        if (b == btok_pkg::CH_E) begin
                            n_depth          = r_depth - btok_pkg::DEPTH_W'(1);
                            n_emit           = 1'b1;
                            n_tok.token_kind = btok_pkg::TK_LIST_END;
                            do_finish        = 1'b1;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                    default: begin
                        do_start = 1'b1;
                    end
                endcase

                if (do_start) begin
                    if (is_digit) begin
                        n_mode = btok_pkg::M_LEN;
                        n_len  = btok_pkg::LENGTH_BITS'(d);
                    end else if (b == btok_pkg::CH_I) begin
                        n_mode       = btok_pkg::M_INT;
                        n_int        = '0;
                        n_neg        = 1'b0;
                        n_digit_seen = 1'b0;
                    end else if (b == btok_pkg::CH_L) begin
                        if (r_depth >= eff_limit) begin
                            n_mode           = btok_pkg::M_DISCARD;
                            n_emit           = 1'b1;
                            n_tok.token_kind = btok_pkg::TK_ERROR;
                            n_tok.error_code = btok_pkg::E_TOO_DEEP;
                        end else begin
                            n_depth          = r_depth + btok_pkg::DEPTH_W'(1);
                            n_mode           = btok_pkg::M_LIST;
                            n_emit           = 1'b1;
                            n_tok.token_kind = btok_pkg::TK_LIST_START;
                        end
                    end else begin
                        n_mode           = btok_pkg::M_DISCARD;
                        n_emit           = 1'b1;
                        n_tok.token_kind = btok_pkg::TK_ERROR;
                        n_tok.error_code = btok_pkg::E_BAD_CHAR;
                    end
                end

                // an element ended: top level done at depth zero, else back to the list
                if (do_finish) begin
                    if (n_depth == '0) begin
                        n_top_done           = 1'b1;
                        n_mode               = btok_pkg::M_IDLE;
                        n_tok.value_complete = 1'b1;
                    end else begin
                        n_mode = btok_pkg::M_LIST;
                    end
                end
            end

            n_tok.nest_depth = n_depth;

            if (eoi) begin
                // truncation replaces any token this byte made
                if (n_mode != btok_pkg::M_DISCARD && !n_top_done) begin
                    n_tok            = '0;
                    n_tok.token_kind = btok_pkg::TK_ERROR;
                    n_tok.error_code = btok_pkg::E_TRUNCATED;
                    n_tok.nest_depth = n_depth;
                    n_emit           = 1'b1;
                end
                n_mode = btok_pkg::M_IDLE;
            end
        end

        // rearm on end of input
        if (eoi) begin
            n_depth      = '0;
            n_len        = '0;
            n_rem        = '0;
            n_int        = '0;
            n_neg        = 1'b0;
            n_digit_seen = 1'b0;
            n_top_done   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_limit <= btok_pkg::DEPTH_W'(btok_pkg::MAX_DEPTH);
        end else if (i_cfg_we) begin
            r_depth_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= btok_pkg::M_IDLE;
            r_depth      <= '0;
            r_len        <= '0;
            r_rem        <= '0;
            r_int        <= '0;
            r_neg        <= 1'b0;
            r_digit_seen <= 1'b0;
            r_top_done   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_mode       <= n_mode;
                r_depth      <= n_depth;
                r_len        <= n_len;
                r_rem        <= n_rem;
                r_int        <= n_int;
                r_neg        <= n_neg;
                r_digit_seen <= n_digit_seen;
                r_top_done   <= n_top_done;
            end
            if (accept && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_tok <= n_tok;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.token_kind     = r_tok.token_kind;
    assign o_out.int_value      = r_tok.int_value;
    assign o_out.str_length     = r_tok.str_length;
    assign o_out.data_byte      = r_tok.data_byte;
    assign o_out.last_of_string = r_tok.last_of_string;
    assign o_out.nest_depth     = r_tok.nest_depth;
    assign o_out.error_code     = r_tok.error_code;
    assign o_out.value_complete = r_tok.value_complete;

endmodule

// ===== rtl/btok_checker.sv =====
// port-level checks for the tokenizer core and their bind
`include "assert_macros.svh"

module btok_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [2:0]                   i_token_kind,
    input  logic [btok_pkg::DEPTH_W-1:0] i_nest_depth,
    input  logic                         i_value_complete
);

    logic depth_ok;
    logic is_error;

    assign depth_ok = i_nest_depth <= btok_pkg::DEPTH_W'(btok_pkg::MAX_DEPTH);
    assign is_error = i_token_kind == btok_pkg::TK_ERROR;

    `BTOK_ASSERT(a_out_held, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `BTOK_ASSERT(a_kind_range, i_clk, i_rst_n, i_out_valid |-> i_token_kind <= btok_pkg::TK_ERROR)
    `BTOK_ASSERT(a_depth_range, i_clk, i_rst_n, i_out_valid |-> depth_ok)
    `BTOK_ASSERT(a_err_not_done, i_clk, i_rst_n, i_out_valid && is_error |-> !i_value_complete)
    `BTOK_ASSERT_ALWAYS(a_idle_after_reset, i_clk, $rose(i_rst_n) |-> !i_out_valid)

endmodule

bind bencode_tokenizer_core btok_checker u_btok_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_token_kind     (o_out.token_kind),
    .i_nest_depth     (o_out.nest_depth),
    .i_value_complete (o_out.value_complete)
);

// ===== dv/tb.sv =====
// testbench for the bencode tokenizer: directed and random byte streams checked token by token
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btok_pkg::*;

    localparam int          QUIET_LIMIT = 3000;
    localparam logic [63:0] LEN_MAX     = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam logic [63:0] POS_INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_INT_MAX = 64'h8000_0000_0000_0000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [DEPTH_W-1:0] i_cfg_wdata;

    btok_in_if  in_ch ();
    btok_out_if tok_ch ();

    bencode_tokenizer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (tok_ch)
    );

    // parser state mirrored by the predictor
    logic [2:0]         pmode;
    logic [DEPTH_W-1:0] depth_now;
    logic [63:0]        len_acc;
    logic [63:0]        bytes_left;
    logic [63:0]        int_acc;
    logic               int_neg;
    logic               int_digit;
    logic               value_done;
    logic [DEPTH_W-1:0] cfg_limit;

    t_token   due_tokens[$];
    bit [7:0] stream_q[$];
    int       err_count       = 0;
    int       quiet_cycles    = 0;
    int       hold_off_cycles = 0;
    bit       src_idle        = 1'b0;
    bit       sink_idle       = 1'b0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic void rearm_parser();
        pmode      = M_IDLE;
        depth_now  = '0;
        len_acc    = '0;
        bytes_left = '0;
        int_acc    = '0;
        int_neg    = 1'b0;
        int_digit  = 1'b0;
        value_done = 1'b0;
    endfunction

    function automatic t_token make_token(input logic [2:0] kind, input logic [63:0] ival,
                                          input logic [31:0] slen, input logic [7:0] dbyte,
                                          input logic last, input logic [2:0] code,
                                          input logic done);
        t_token tok;
        tok.token_kind     = kind;
        tok.int_value      = ival;
        tok.str_length     = slen;
        tok.data_byte      = dbyte;
        tok.last_of_string = last;
        tok.nest_depth     = depth_now;
        tok.error_code     = code;
        tok.value_complete = done;
        return tok;
    endfunction

    function automatic t_token raise_error(input logic [2:0] code);
        pmode = M_DISCARD;
        return make_token(TK_ERROR, '0, '0, '0, 1'b0, code, 1'b0);
    endfunction

    // an element just ended: true when it was the top-level value
    function automatic logic close_element();
        if (depth_now == 0) begin
            value_done = 1'b1;
            pmode      = M_IDLE;
            return 1'b1;
        end
        pmode = M_LIST;
        return 1'b0;
    endfunction

    function automatic bit open_value(input logic [7:0] b, output t_token tok);
        logic [DEPTH_W-1:0] lim;
        tok = '0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            pmode   = M_LEN;
            len_acc = {56'd0, b - CH_ZERO};
            return 1'b0;
        end
        if (b == CH_I) begin
            pmode     = M_INT;
            int_acc   = '0;
            int_neg   = 1'b0;
            int_digit = 1'b0;
            return 1'b0;
        end
        if (b == CH_L) begin
            lim = (cfg_limit < DEPTH_W'(MAX_DEPTH)) ? cfg_limit : DEPTH_W'(MAX_DEPTH);
            if (depth_now >= lim) begin
                tok = raise_error(E_TOO_DEEP);
                return 1'b1;
            end
            depth_now++;
            pmode = M_LIST;
            tok   = make_token(TK_LIST_START, '0, '0, '0, 1'b0, '0, 1'b0);
            return 1'b1;
        end
        tok = raise_error(E_BAD_CHAR);
        return 1'b1;
    endfunction

    // advances the mirrored parser by one byte; true when the byte yields a token
    function automatic bit tokenize_byte(input logic [7:0] b, input logic eoi, output t_token tok);
        bit          have;
        logic        dig;
        logic        done;
        logic [63:0] d;
        logic [63:0] lim;
        tok  = '0;
        have = 1'b0;
        if (pmode == M_DISCARD) begin
            if (eoi)
                rearm_parser();
            return 1'b0;
        end
        dig = (b >= CH_ZERO && b <= CH_NINE);
        d   = {56'd0, b - CH_ZERO};
        if (value_done) begin
            tok  = raise_error(E_TRAILING);
            have = 1'b1;
        end else begin
            case (pmode)
                M_LEN: begin
                    have = 1'b1;
                    if (dig) begin
                        if (len_acc > (LEN_MAX - d) / 10) begin
                            tok = raise_error(E_LEN_OVERFLOW);
                        end else begin
                            len_acc = len_acc * 10 + d;
                            have    = 1'b0;
                        end
                    end else if (b != CH_COLON) begin
                        tok = raise_error(E_BAD_LENGTH);
                    end else if (len_acc == 0) begin
                        done = close_element();
                        tok  = make_token(TK_STR_HEADER, '0, '0, '0, 1'b0, '0, done);
                    end else begin
                        bytes_left = len_acc;
                        pmode      = M_PAYLOAD;
                        tok = make_token(TK_STR_HEADER, '0, len_acc[31:0], '0, 1'b0, '0, 1'b0);
                    end
                end
                M_PAYLOAD: begin
                    bytes_left--;
                    done = 1'b0;
                    if (bytes_left == 0)
                        done = close_element();
                    tok  = make_token(TK_STR_BYTE, '0, '0, b, bytes_left == 0, '0, done);
                    have = 1'b1;
                end
                M_INT: begin
                    have = 1'b1;
                    lim  = int_neg ? NEG_INT_MAX : POS_INT_MAX;
                    if (dig) begin
                        // leading zero, then minus zero
                        if (int_digit && int_acc == 0) begin
                            tok = raise_error(E_BAD_INTEGER);
                        end else if (!int_digit && d == 0 && int_neg) begin
                            tok = raise_error(E_BAD_INTEGER);
                        end else if (int_acc > (lim - d) / 10) begin
                            tok = raise_error(E_INT_OVERFLOW);
                        end else begin
                            int_acc   = int_acc * 10 + d;
                            int_digit = 1'b1;
                            have      = 1'b0;
                        end
                    end else if (b == CH_MINUS && !int_digit && !int_neg) begin
                        int_neg = 1'b1;
                        have    = 1'b0;
                    end else if (b == CH_E && int_digit) begin
                        done = close_element();
                        tok  = make_token(TK_INTEGER, int_neg ? -int_acc : int_acc, '0, '0,
                                          1'b0, '0, done);
                    end else begin
                        tok = raise_error(E_BAD_INTEGER);
                    end
                end
                M_LIST: begin
                    if (b == CH_E) begin
                        depth_now--;
                        done = close_element();
                        tok  = make_token(TK_LIST_END, '0, '0, '0, 1'b0, '0, done);
                        have = 1'b1;
                    end else begin
                        have = open_value(b, tok);
                    end
                end
                default: have = open_value(b, tok);
            endcase
        end
        if (eoi) begin
            // an unfinished value ends in truncation, replacing any token of this byte
            if (pmode != M_DISCARD && !value_done) begin
                tok  = make_token(TK_ERROR, '0, '0, '0, 1'b0, E_TRUNCATED, 1'b0);
                have = 1'b1;
            end
            rearm_parser();
        end
        return have;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : token_monitor
        t_token got;
        t_token want;
        t_token next_tok;
        if (i_rst_n) begin
            if (i_cfg_we)
                cfg_limit = i_cfg_wdata;
            if (tok_ch.valid && tok_ch.ready) begin
                got.token_kind     = tok_ch.token_kind;
                got.int_value      = tok_ch.int_value;
                got.str_length     = tok_ch.str_length;
                got.data_byte      = tok_ch.data_byte;
                got.last_of_string = tok_ch.last_of_string;
                got.nest_depth     = tok_ch.nest_depth;
                got.error_code     = tok_ch.error_code;
                got.value_complete = tok_ch.value_complete;
                if (due_tokens.size() == 0) begin
                    report_mismatch($sformatf("unexpected token kind %0d", got.token_kind));
                end else begin
                    want = due_tokens.pop_front();
                    check_field("token_kind", got.token_kind, want.token_kind);
                    check_field("int_value", got.int_value, want.int_value);
                    check_field("str_length", got.str_length, want.str_length);
                    check_field("data_byte", got.data_byte, want.data_byte);
                    check_field("last_of_string", got.last_of_string, want.last_of_string);
                    check_field("nest_depth", got.nest_depth, want.nest_depth);
                    check_field("error_code", got.error_code, want.error_code);
                    check_field("value_complete", got.value_complete, want.value_complete);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (tokenize_byte(in_ch.in_byte, in_ch.end_of_input, next_tok))
                    due_tokens.insert(due_tokens.size(), next_tok);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // token sink: random stall bursts plus a long hold-off on request
    initial begin : token_sink
        tok_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                tok_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else if (sink_idle && $urandom_range(0, 7) == 0) begin
                tok_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                tok_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        if (src_idle && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.end_of_input <= eoi;
        @(posedge i_clk iff (in_ch.valid && in_ch.ready));
    endtask

    task automatic send_stream();
        foreach (stream_q[i])
            send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    function automatic void append_byte(input bit [7:0] v);
        stream_q.insert(stream_q.size(), v);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    task automatic send_text(input string s);
        stream_q.delete();
        push_text(s);
        send_stream();
    endtask

    task automatic wait_for_tokens();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (due_tokens.size() != 0)
            @(posedge i_clk);
        // a byte that makes no token may still be in the parser
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_depth_limit(input int limit);
        wait_for_tokens();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= DEPTH_W'(limit);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic bit [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return CH_I;
            1: return CH_L;
            2: return CH_E;
            3: return CH_COLON;
            4: return CH_MINUS;
            5: return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one top-level value, lists built level by level with a count of children left
    function automatic void build_value();
        int     rem [0:4];
        int     lvl;
        int     len;
        longint v;
        string  digits;
        lvl = 0;
        do begin
            if (lvl > 0)
                rem[lvl]--;
            if ($urandom_range(0, 99) < 30 && lvl < 4) begin
                append_byte(CH_L);
                lvl++;
                rem[lvl] = $urandom_range(0, 3);
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                        case ($urandom_range(0, 4))
                            0: v = $urandom_range(0, 9);
                            1: v = $urandom_range(0, 1000000);
                            2: v = {$urandom, $urandom};
                            3: v = POS_INT_MAX;
                            default: v = NEG_INT_MAX;
                        endcase
                        if ($urandom_range(0, 2) == 0 && v >= 0 && v <= 1000000)
                            v = -v;
                        digits = $sformatf("%0d", v);
                        // an extra digit may push past the 64-bit range
                        if ($urandom_range(0, 9) == 0)
                            digits = {digits, "7"};
                        push_text({"i", digits, "e"});
                    end
                    9, 10, 11, 12, 13, 14, 15, 16, 17: begin
                        len = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 40)
                                                           : $urandom_range(0, 8);
                        digits = $sformatf("%0d", len);
                        if ($urandom_range(0, 5) == 0)
                            digits = {"00", digits};
                        push_text({digits, ":"});
                        repeat (len) append_byte(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        case ($urandom_range(0, 9))
                            0: push_text("i00e");
                            1: push_text("i-0e");
                            2: push_text("i-e");
                            3: push_text("ie");
                            4: push_text("i3-e");
                            5: push_text("4294967296:");
                            6: push_text("4294967295:");
                            7: push_text("12x");
                            8: push_text("i--5e");
                            default: push_text("99999999999:");
                        endcase
                    end
                endcase
            end
            while (lvl > 0 && rem[lvl] == 0) begin
                append_byte(CH_E);
                lvl--;
            end
        end while (lvl > 0);
    endfunction

    // mostly well-formed values, some damaged, some pure noise
    function automatic void make_stream();
        int n;
        stream_q.delete();
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 6);
            repeat (n) append_byte(noise_byte());
            return;
        end
        build_value();
        case ($urandom_range(0, 19))
            0: stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom_range(0, 255));
            1: begin
                if (stream_q.size() > 1) begin
                    n = $urandom_range(1, stream_q.size() - 1);
                    stream_q = stream_q[0:n-1];
                end
            end
            2: repeat ($urandom_range(1, 3)) append_byte(noise_byte());
            3: stream_q.insert($urandom_range(0, stream_q.size() - 1), noise_byte());
            default: ;
        endcase
    endfunction

    task automatic run_streams(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            make_stream();
            send_stream();
            sent += stream_q.size();
        end
    endtask

    task automatic test_directed();
        string forms[$];
        forms = '{"i0e", "i9223372036854775807e", "i-9223372036854775808e",
                  "i9223372036854775808e", "i-9223372036854775809e", "i05e", "i-0e",
                  "i-e", "ie", "i1-2e", "i--3e", "0:", "3:abc", "007:bencode",
                  "4294967296:", "4294967295:", "12x", "x", "e", "lx", "le",
                  "li42e4:spaml0:eee", "i7ei7e", "i5", "l3:ab"};
        foreach (forms[k])
            send_text(forms[k]);
        // payload bytes at both ends of the byte range
        stream_q.delete();
        push_text("2:");
        append_byte(8'h00);
        append_byte(8'hFF);
        send_stream();
    endtask

    task automatic test_depth_limit();
        int limits[5] = '{1, 16, 0, 31, 3};
        int eff;
        foreach (limits[k]) begin
            set_depth_limit(limits[k]);
            eff = (limits[k] < MAX_DEPTH) ? limits[k] : MAX_DEPTH;
            for (int n = (eff > 0) ? eff : 1; n <= eff + 1; n++) begin
                stream_q.delete();
                repeat (n) append_byte(CH_L);
                repeat (n) append_byte(CH_E);
                send_stream();
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 300;
        stream_q.delete();
        push_text("40:");
        repeat (40) append_byte(8'($urandom_range(0, 255)));
        send_stream();
        // sender holds until every token is out
        wait_for_tokens();
    endtask

    task automatic test_random_values();
        int limits[5] = '{16, 2, 1, 4, 9};
        foreach (limits[k]) begin
            set_depth_limit(limits[k]);
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            run_streams(100);
        end
    endtask

    task automatic test_full_rate();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        set_depth_limit(16);
        run_streams(100);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.in_byte      <= '0;
        in_ch.end_of_input <= 1'b0;
        cfg_limit = DEPTH_W'(MAX_DEPTH);
        rearm_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        src_idle  = 1'b1;
        sink_idle = 1'b1;

        test_directed();
        test_depth_limit();
        test_backpressure();
        test_random_values();
        test_full_rate();

        wait_for_tokens();
        repeat (16) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
